// ===== design/ncas_pkg.sv =====
package ncas_pkg;

	// fixed field widths of the item and result beats
	localparam int SLOT_W    = 4;
	localparam int FIELD_W   = 16;
	localparam int CLUSTER_W = 4;
	localparam int DIST_W    = 34;
	localparam int SUM_W     = 48;
	localparam int CFG_W     = 5;

	// widest centroid index the store can ever need
	localparam int TAG_IDX_W = 8;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// item mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_POINT = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic [SLOT_W-1:0]         slot;
		logic signed [FIELD_W-1:0] coord_x;
		logic signed [FIELD_W-1:0] coord_y;
		logic                      first_point;
	} item_t;

	typedef struct packed {
		logic [CLUSTER_W-1:0] cluster;
		logic [DIST_W-1:0]    near_dist;
		logic [SUM_W-1:0]     err_total;
	} result_t;

	// travels with each centroid through the distance pipeline
	typedef struct packed {
		logic                 vld;
		logic                 last;
		logic [TAG_IDX_W-1:0] idx;
	} scan_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== design/ncas_store.sv =====
module ncas_store #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// centroid write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/ncas_dist.sv =====
module ncas_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ncas_pkg::scan_tag_t            tag_in,
	input  logic signed [COORD_BITS-1:0]   px,
	input  logic signed [COORD_BITS-1:0]   py,
	input  logic signed [COORD_BITS-1:0]   cx,
	input  logic signed [COORD_BITS-1:0]   cy,
	output ncas_pkg::scan_tag_t            tag_out,
	output logic [2*COORD_BITS:0]          dist_sq
);

	localparam int CB = COORD_BITS;

	logic signed [CB:0]  dx_full;
	logic signed [CB:0]  dy_full;
	logic [CB-1:0]       dx_abs;
	logic [CB-1:0]       dy_abs;

	ncas_pkg::scan_tag_t tag_s1, tag_s2, tag_s3;
	logic [CB-1:0]       dx_s1, dy_s1;
	logic [2*CB-1:0]     dx2_s2, dy2_s2;
	logic [2*CB:0]       d_s3;

	// absolute coordinate differences
	always_comb begin
		dx_full = {px[CB-1], px} - {cx[CB-1], cx};
		dy_full = {py[CB-1], py} - {cy[CB-1], cy};
		dx_abs  = dx_full[CB] ? CB'(-dx_full) : dx_full[CB-1:0];
		dy_abs  = dy_full[CB] ? CB'(-dy_full) : dy_full[CB-1:0];
	end

	// tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// diff, square, sum stages
	always_ff @(posedge clk) begin
		dx_s1  <= dx_abs;
		dy_s1  <= dy_abs;
		dx2_s2 <= dx_s1 * dx_s1;
		dy2_s2 <= dy_s1 * dy_s1;
		d_s3   <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
	end

	assign tag_out = tag_s3;
	assign dist_sq = d_s3;

endmodule

// ===== design/nearest_centroid_assign_sse_core.sv =====
// Nearest-centroid assignment with a running sum of squared errors. An item
// beat with mode load writes one (x, y) centroid into a slot of the store and
// returns no result. A point beat scans slots 0 to cluster_count-1 (0 counts
// as 1, values above MAX_CLUSTERS count as MAX_CLUSTERS) and returns the
// nearest slot (lowest on ties), its squared distance and the running error
// sum, which restarts at a point marked first and saturates at all ones. A
// point holds off further items while the centroid store, with separate write
// and read ports, is read one entry per cycle, then the read/difference/square/
// sum/compare pipeline drains. A finished result waits in its own register, so
// the next beat is taken while it is unclaimed; only a second finished result
// stalls. cfg_ready is always high; write the register only while no point is
// in flight. Slots never loaded must not fall inside the scanned range.
module nearest_centroid_assign_sse_core #(
	parameter int MAX_CLUSTERS = 16,
	parameter int COORD_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  ncas_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ncas_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ncas_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CB     = COORD_BITS;
	localparam int IDX_W  = $clog2(MAX_CLUSTERS);
	localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int RAW_W  = (CB > ncas_pkg::FIELD_W) ? CB : ncas_pkg::FIELD_W;
	localparam int D_W    = 2 * CB + 1;
	localparam int SUM_W  = ncas_pkg::SUM_W;
	localparam int CMP_W  = (D_W > SUM_W) ? D_W : SUM_W;
	localparam int CLU_W  = ncas_pkg::CLUSTER_W;
	localparam int DST_W  = ncas_pkg::DIST_W;
	localparam int TIDX_W = ncas_pkg::TAG_IDX_W;

	ncas_pkg::state_t state_q, state_d;

	logic [ncas_pkg::CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0]           n_sat;
	logic [CNT_W-1:0]           n_q;
	logic [CNT_W-1:0]           issue_cnt_q;
	logic signed [CB-1:0]       px_q, py_q;
	logic                       first_q;

	logic [RAW_W-1:0]           raw_x, raw_y;
	logic signed [CB-1:0]       in_x, in_y;
	logic                       item_acc;
	logic                       load_wr;
	logic                       point_acc;
	logic                       rd_en;
	logic                       issue_last;
	logic                       result_load;

	logic [2*CB-1:0]            rd_data;
	ncas_pkg::scan_tag_t        rd_tag, rd_tag_s1, d_tag;
	logic [D_W-1:0]             d_val;
	logic                       cmp_take;

	logic [D_W-1:0]             best_d_q;
	logic [IDX_W-1:0]           best_idx_q;

	logic [SUM_W-1:0]           error_sum_q;
	logic [SUM_W-1:0]           sum_base;
	logic [SUM_W-1:0]           sum_room;
	logic [SUM_W-1:0]           sum_next;

	logic                       result_valid_q;
	ncas_pkg::result_t          result_q;

	// config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ncas_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// active centroid count, saturated to 1..MAX_CLUSTERS
	always_comb begin
		if (cfg_q == '0) begin
			n_sat = CNT_W'(1);
		end else if (32'(cfg_q) > MAX_CLUSTERS) begin
			n_sat = CNT_W'(MAX_CLUSTERS);
		end else begin
			n_sat = CNT_W'(cfg_q);
		end
	end

	// field bits read as COORD_BITS-wide two's complement
	always_comb begin
		raw_x = RAW_W'($unsigned(item.coord_x));
		raw_y = RAW_W'($unsigned(item.coord_y));
		in_x  = $signed(raw_x[CB-1:0]);
		in_y  = $signed(raw_y[CB-1:0]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ncas_pkg::ST_IDLE: begin
				if (point_acc) begin
					state_d = ncas_pkg::ST_SCAN;
				end
			end
			ncas_pkg::ST_SCAN: begin
				if (issue_last) begin
					state_d = ncas_pkg::ST_DRAIN;
				end
			end
			ncas_pkg::ST_DRAIN: begin
				if (d_tag.vld && d_tag.last) begin
					state_d = ncas_pkg::ST_DONE;
				end
			end
			ncas_pkg::ST_DONE: begin
				if (result_load) begin
					state_d = ncas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ncas_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		item_stall  = 1'b1;
		rd_en       = 1'b0;
		result_load = 1'b0;
		case (state_q)
			ncas_pkg::ST_IDLE: begin
				item_stall = 1'b0;
			end
			ncas_pkg::ST_SCAN: begin
				rd_en = 1'b1;
			end
			ncas_pkg::ST_DRAIN: begin
			end
			ncas_pkg::ST_DONE: begin
				result_load = !result_valid_q || !result_stall;
			end
			default: begin
			end
		endcase
	end

	assign item_acc   = item_valid && !item_stall;
	assign point_acc  = item_acc && (item.mode == ncas_pkg::MODE_POINT);
	assign load_wr    = item_acc && (item.mode == ncas_pkg::MODE_LOAD)
		&& (32'(item.slot) < MAX_CLUSTERS);
	assign issue_last = rd_en && (issue_cnt_q == n_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// point latch and read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			n_q         <= CNT_W'(1);
			first_q     <= 1'b0;
		end else if (point_acc) begin
			issue_cnt_q <= '0;
			n_q         <= n_sat;
			first_q     <= item.first_point;
		end else if (rd_en) begin
			issue_cnt_q <= issue_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (point_acc) begin
			px_q <= in_x;
			py_q <= in_y;
		end
	end

	// centroid store, interlocked: loads only while no scan runs
	ncas_store #(
		.DEPTH  (MAX_CLUSTERS),
		.DATA_W (2 * CB)
	) u_store (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (IDX_W'(item.slot)),
		.wr_data ({in_x, in_y}),
		.rd_en   (rd_en),
		.rd_addr (issue_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// tag is registered alongside the store read so it lines up with the read data
	always_comb begin
		rd_tag.vld  = rd_en;
		rd_tag.last = issue_last;
		rd_tag.idx  = TIDX_W'(issue_cnt_q[IDX_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_s1 <= '0;
		end else begin
			rd_tag_s1 <= rd_tag;
		end
	end

	ncas_dist #(
		.COORD_BITS (CB)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (rd_tag_s1),
		.px      (px_q),
		.py      (py_q),
		.cx      ($signed(rd_data[2*CB-1:CB])),
		.cy      ($signed(rd_data[CB-1:0])),
		.tag_out (d_tag),
		.dist_sq (d_val)
	);

	// running minimum, strict less keeps the lower slot on ties
	assign cmp_take = d_tag.vld && ((d_tag.idx == '0) || (d_val < best_d_q));

	always_ff @(posedge clk) begin
		if (cmp_take) begin
			best_d_q   <= d_val;
			best_idx_q <= d_tag.idx[IDX_W-1:0];
		end
	end

	// saturating error sum update
	always_comb begin
		sum_base = first_q ? '0 : error_sum_q;
		sum_room = ncas_pkg::SUM_MAX - sum_base;
		if (CMP_W'(best_d_q) >= CMP_W'(sum_room)) begin
			sum_next = ncas_pkg::SUM_MAX;
		end else begin
			sum_next = sum_base + SUM_W'(best_d_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
		end else if (result_load) begin
			error_sum_q <= sum_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.cluster   <= CLU_W'(best_idx_q);
			result_q.near_dist <= DST_W'(best_d_q);
			result_q.err_total <= sum_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// reads never run past the active centroid count
	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ncas_pkg::ST_SCAN) |-> (issue_cnt_q < n_q))
		else $error("centroid read beyond active count");

	// last distance reaches the compare only after all reads are issued
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(d_tag.vld && d_tag.last) |-> (state_q == ncas_pkg::ST_DRAIN))
		else $error("final distance outside drain");

	// a new result beat appears only after a finished scan
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ncas_pkg::ST_DONE))
		else $error("result without finished scan");

	// the error sum never shrinks unless a first point restarts it
	a_sum_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_load && !first_q) |-> (sum_next >= error_sum_q))
		else $error("error sum decreased");
`endif

endmodule
